// ----- src/mbps_pkg.sv -----
// Shared constants and types of the masked byte pattern scanner.
// Used by the channel interfaces, every module of the block and the checker.
package mbps_pkg;

    localparam int PATTERN_MAX_DEF = 16;   // window depth in bytes
    localparam int PATTERN_BYTES   = 16;   // pattern bytes held in configuration
    localparam int BYTE_W          = 8;
    localparam int ADDR_W          = 64;
    localparam int CFG_DATA_W      = 64;
    localparam int CFG_IDX_W       = 2;
    localparam int MASK_W          = 16;
    localparam int LEN_W           = 5;
    localparam int SEL_W           = $clog2(PATTERN_BYTES);
    localparam int QUEUE_DEPTH     = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_LOW    = 2'd0,
        CFG_PATTERN_HIGH   = 2'd1,
        CFG_CARE_MASK      = 2'd2,
        CFG_PATTERN_LENGTH = 2'd3
    } cfg_index_t;

    typedef logic [ADDR_W-1:0] addr_t;

    // Front to queue: one request per matching byte
    typedef struct packed {
        logic  push;
        addr_t addr;
    } match_req_t;

    // Queue to back: oldest waiting request
    typedef struct packed {
        logic  avail;
        addr_t addr;
    } queue_head_t;

endpackage

// ----- src/mbps_scan_if.sv -----
// Input channel of the scanner: one buffer byte per request.
// Depends on mbps_pkg for field widths.
interface mbps_scan_if;
    import mbps_pkg::*;

    logic                valid;
    logic                ready;
    logic [BYTE_W-1:0]   data_byte;
    logic                start_of_buffer;
    logic [ADDR_W-1:0]   base_address;

    modport source (output valid, data_byte, start_of_buffer, base_address, input ready);
    modport sink   (input valid, data_byte, start_of_buffer, base_address, output ready);
endinterface

// ----- src/mbps_hit_if.sv -----
// Output channel of the scanner: one match address per request.
// Depends on mbps_pkg for field widths.
interface mbps_hit_if;
    import mbps_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   match_address;

    modport source (output valid, match_address, input ready);
    modport sink   (input valid, match_address, output ready);
endinterface

// ----- src/mbps_front.sv -----
// Front part: configuration registers, byte window, address tracking and the
// parallel masked compare. Pushes one request into the queue per match.
// Depends on mbps_pkg and mbps_scan_if.
module mbps_front #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mbps_scan_if.sink                           scan,
    input  logic                                cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                q_full,
    output mbps_pkg::match_req_t                req
);
    import mbps_pkg::*;

    localparam int CNT_W = $clog2(PATTERN_MAX + 1);

    logic [ADDR_W-1:0]          pat_lo_reg;
    logic [ADDR_W-1:0]          pat_hi_reg;
    logic [MASK_W-1:0]          care_reg;
    logic [LEN_W-1:0]           len_reg;

    logic [BYTE_W-1:0]          window_reg  [PATTERN_MAX];
    logic [BYTE_W-1:0]          window_next [PATTERN_MAX];
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    addr_t                      addr_reg;
    addr_t                      this_addr;

    logic                       accept;
    logic [CNT_W-1:0]           eff_len;
    logic [2*ADDR_W-1:0]        pat_all;
    logic                       hit_ok;

    assign scan.ready = !q_full;
    assign accept     = scan.valid && scan.ready;
    assign pat_all    = {pat_hi_reg, pat_lo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_lo_reg <= '0;
            pat_hi_reg <= '0;
            care_reg   <= '0;
            len_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_PATTERN_LOW:    pat_lo_reg <= cfg_data[ADDR_W-1:0];
                CFG_PATTERN_HIGH:   pat_hi_reg <= cfg_data[ADDR_W-1:0];
                CFG_CARE_MASK:      care_reg   <= cfg_data[MASK_W-1:0];
                CFG_PATTERN_LENGTH: len_reg    <= cfg_data[LEN_W-1:0];
            endcase
        end
    end

    // Lengths beyond the window act as a full window
    always_comb
    begin
        if (int'(len_reg) > PATTERN_MAX)
            eff_len = CNT_W'(PATTERN_MAX);
        else
            eff_len = CNT_W'(len_reg);
    end

    always_comb
    begin
        window_next[0] = scan.data_byte;
        for (int i = 1; i < PATTERN_MAX; i++)
            window_next[i] = window_reg[i-1];
    end

    always_comb
    begin
        this_addr = scan.start_of_buffer ? addr_t'(scan.base_address) : addr_reg;
        if (scan.start_of_buffer)
            count_next = CNT_W'(1);
        else if (count_reg == CNT_W'(PATTERN_MAX))
            count_next = count_reg;
        else
            count_next = count_reg + CNT_W'(1);
    end

    // Window slot i holds the byte for pattern position eff_len-1-i; positions
    // past the configured pattern bytes match anything.
    always_comb
    begin
        int               pos;
        logic [SEL_W-1:0] sel;
        hit_ok = (eff_len != '0) && (count_next >= eff_len);
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            pos = int'(eff_len) - 1 - i;
            sel = SEL_W'(pos);
            if ((i < int'(eff_len)) && (pos < PATTERN_BYTES) && care_reg[sel])
            begin
                if (window_next[i] != pat_all[{sel, 3'b000} +: BYTE_W])
                    hit_ok = 1'b0;
            end
        end
    end

    assign req.push = accept && hit_ok;
    assign req.addr = this_addr - addr_t'(eff_len) + addr_t'(1);

    always_ff @(posedge clk)
    begin
        if (accept)
            window_reg <= window_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            addr_reg  <= '0;
        end
        else if (accept)
        begin
            count_reg <= count_next;
            addr_reg  <= this_addr + addr_t'(1);
        end
    end

endmodule

// ----- src/mbps_queue.sv -----
// Short queue of match addresses between the front and back parts.
// Depends on mbps_pkg.
module mbps_queue #(
    parameter int DEPTH = mbps_pkg::QUEUE_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbps_pkg::match_req_t    req,
    output logic                    full,
    output mbps_pkg::queue_head_t   head,
    input  logic                    pop
);
    import mbps_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    addr_t              slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head.avail = (count_reg != '0);
    assign head.addr  = slot_reg[rd_ptr_reg];
    assign do_pop     = pop && head.avail;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (req.push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (req.push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !req.push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (req.push)
            slot_reg[wr_ptr_reg] <= req.addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- src/mbps_back.sv -----
// Back part: output register that presents match addresses to the receiver.
// Depends on mbps_pkg and mbps_hit_if.
module mbps_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mbps_pkg::queue_head_t   head,
    output logic                    pop,
    mbps_hit_if.source              hits
);
    import mbps_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    addr_t  addr_reg;
    logic   load;

    // Refill whenever the register is empty or being taken
    assign load = head.avail && (!valid_reg || hits.ready);
    assign pop  = load;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (hits.ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            addr_reg <= head.addr;
    end

    assign hits.valid         = valid_reg;
    assign hits.match_address = addr_reg;

endmodule

// ----- src/masked_byte_pattern_scanner_top.sv -----
// Masked byte pattern scanner: front (window and compare), queue, back (output).
// Depends on mbps_pkg, mbps_scan_if, mbps_hit_if, mbps_front, mbps_queue, mbps_back.
//
// Usage:
//   scan  - byte stream; a request carries data_byte, start_of_buffer and
//           base_address (read only with start_of_buffer set).
//   hits  - one match_address request per input byte that completes a match,
//           in input order; overlapping matches are all reported.
//   cfg   - write port (cfg_we, cfg_index, cfg_data): pattern bytes low and
//           high, care mask, pattern length. Write only while the block is idle.
// Throughput: one byte per cycle while scan.ready is high; the window
//   compare is done in the cycle the byte is taken.
// Path: a match is queued when its byte is taken, then moved from the queue
//   into the output register, which drives hits.
// Reset: configuration, byte count and running address clear to zero; the
//   queue and the output register empty.
// Stall: while hits is stalled the queue fills; with two matches queued behind
//   the output register, scan.ready drops until the receiver takes a result.
module masked_byte_pattern_scanner_top #(
    parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mbps_scan_if.sink                           scan,
    mbps_hit_if.source                          hits,
    input  logic                                cfg_we,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mbps_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import mbps_pkg::*;

    match_req_t   req;
    queue_head_t  head;
    logic         q_full;
    logic         pop;

    mbps_front #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .scan      (scan),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .req       (req)
    );

    mbps_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .full  (q_full),
        .head  (head),
        .pop   (pop)
    );

    mbps_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .pop   (pop),
        .hits  (hits)
    );

endmodule

// ----- src/mbps_checker.sv -----
// Port-level checks of the scanner top level, attached by bind.
// Depends on mbps_pkg and masked_byte_pattern_scanner_top.
module mbps_port_sva (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        scan_valid,
    input  logic                        scan_ready,
    input  logic                        hits_valid,
    input  logic                        hits_ready,
    input  logic [mbps_pkg::ADDR_W-1:0] hits_addr
);
    import mbps_pkg::*;

    // A result appearing on an empty output comes from an accepted byte via the queue
    a_hit_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(hits_valid) |-> $past(scan_valid && scan_ready, 2))
        else $error("match request without an accepted byte two cycles earlier");

    // Input backpressure only follows an output stall
    a_ready_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !scan_ready |-> $past(hits_valid && !hits_ready))
        else $error("scan stalled while the output was flowing");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        hits_valid && !hits_ready |=> hits_valid && $stable(hits_addr))
        else $error("stalled match request changed");

endmodule

bind masked_byte_pattern_scanner_top mbps_port_sva u_mbps_port_sva (
    .clk        (clk),
    .rst_n      (rst_n),
    .scan_valid (scan.valid),
    .scan_ready (scan.ready),
    .hits_valid (hits.valid),
    .hits_ready (hits.ready),
    .hits_addr  (hits.match_address)
);
